>>> sv/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, character codes and lookup functions for the json escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int RunMax = 6;
    localparam int IdxW   = $clog2(RunMax);

    // ascii codes used by the escape sequences
    localparam logic [6:0] ChBslash = 7'h5C;
    localparam logic [6:0] ChQuote  = 7'h22;
    localparam logic [6:0] ChU      = 7'h75;
    localparam logic [6:0] ChB      = 7'h62;
    localparam logic [6:0] ChF      = 7'h66;
    localparam logic [6:0] ChN      = 7'h6E;
    localparam logic [6:0] ChR      = 7'h72;
    localparam logic [6:0] ChT      = 7'h74;

    // input byte codes with special handling
    localparam logic [7:0] BtQuote  = 8'h22;
    localparam logic [7:0] BtBslash = 8'h5C;
    localparam logic [7:0] BtBs     = 8'h08;
    localparam logic [7:0] BtFf     = 8'h0C;
    localparam logic [7:0] BtLf     = 8'h0A;
    localparam logic [7:0] BtCr     = 8'h0D;
    localparam logic [7:0] BtTab    = 8'h09;
    localparam logic [7:0] BtSpace  = 8'h20;
    localparam logic [7:0] BtHigh   = 8'h80;
    localparam logic [7:0] BtLatin  = 8'hA0;

    // one escaped run: characters in emit order, index of the final one
    typedef struct packed {
        logic [RunMax-1:0][6:0] chars;
        logic [IdxW-1:0]        last_idx;
    } t_run;

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 7'h30 + {3'b000, v};
        end
        return 7'h57 + {3'b000, v};
    endfunction

    // code points for 0x80..0x9f; undefined slots map to themselves
    function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
        case (idx)
            5'h00: return 16'h20AC;
            5'h01: return 16'h0081;
            5'h02: return 16'h201A;
            5'h03: return 16'h0192;
            5'h04: return 16'h201E;
            5'h05: return 16'h2026;
            5'h06: return 16'h2020;
            5'h07: return 16'h2021;
            5'h08: return 16'h02C6;
            5'h09: return 16'h2030;
            5'h0A: return 16'h0160;
            5'h0B: return 16'h2039;
            5'h0C: return 16'h0152;
            5'h0D: return 16'h008D;
            5'h0E: return 16'h017D;
            5'h0F: return 16'h008F;
            5'h10: return 16'h0090;
            5'h11: return 16'h2018;
            5'h12: return 16'h2019;
            5'h13: return 16'h201C;
            5'h14: return 16'h201D;
            5'h15: return 16'h2022;
            5'h16: return 16'h2013;
            5'h17: return 16'h2014;
            5'h18: return 16'h02DC;
            5'h19: return 16'h2122;
            5'h1A: return 16'h0161;
            5'h1B: return 16'h203A;
            5'h1C: return 16'h0153;
            5'h1D: return 16'h009D;
            5'h1E: return 16'h017E;
            default: return 16'h0178;
        endcase
    endfunction

endpackage

>>> sv/jse_encode.sv
// ----------------------------------------------------------------------------
// jse_encode
// combinational mapping of one cp1252 byte to its escaped character run
// ----------------------------------------------------------------------------
module jse_encode (
    input  logic [7:0]    i_byte,
    output jse_pkg::t_run o_run
);
    import jse_pkg::*;

    logic [15:0] cp;
    logic        pair;
    logic [6:0]  second;

    always_comb begin
        pair   = 1'b1;
        second = ChQuote;
        unique case (i_byte)
            BtQuote:  second = ChQuote;
            BtBslash: second = ChBslash;
            BtBs:     second = ChB;
            BtFf:     second = ChF;
            BtLf:     second = ChN;
            BtCr:     second = ChR;
            BtTab:    second = ChT;
            default:  pair   = 1'b0;
        endcase
    end

    // code point for the \u form
    always_comb begin
        if (i_byte >= BtHigh && i_byte < BtLatin) begin
            cp = cp1252_high(i_byte[4:0]);
        end else begin
            cp = {8'h00, i_byte};
        end
    end

    always_comb begin
        o_run = '0;
        if (pair) begin
            o_run.chars[0] = ChBslash;
            o_run.chars[1] = second;
            o_run.last_idx = IdxW'(1);
        end else if (i_byte >= BtSpace && i_byte < BtHigh) begin
            o_run.chars[0] = i_byte[6:0];
            o_run.last_idx = IdxW'(0);
        end else begin
            o_run.chars[0] = ChBslash;
            o_run.chars[1] = ChU;
            o_run.chars[2] = hex_char(cp[15:12]);
            o_run.chars[3] = hex_char(cp[11:8]);
            o_run.chars[4] = hex_char(cp[7:4]);
            o_run.chars[5] = hex_char(cp[3:0]);
            o_run.last_idx = IdxW'(RunMax - 1);
        end
    end

endmodule

>>> sv/jse_serial.sv
// ----------------------------------------------------------------------------
// jse_serial
// run register that hands out one character per output transaction
// ----------------------------------------------------------------------------
module jse_serial (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_run_valid,
    input  jse_pkg::t_run i_run,
    output logic          o_load,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [6:0]    o_out_char,
    output logic          o_last_of_run
);
    import jse_pkg::*;

    t_run            r_run;
    logic            r_busy;
    logic [IdxW-1:0] r_idx;
    logic            n_busy;
    logic [IdxW-1:0] n_idx;
    logic            at_last;
    logic            take;

    assign at_last = (r_idx == r_run.last_idx);
    assign take    = r_busy && !i_stall;
    // refill when empty or when the final character leaves this cycle
    assign o_load  = i_run_valid && (!r_busy || (take && at_last));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (take) begin
            if (at_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + IdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_run <= i_run;
        end
    end

    assign o_valid       = r_busy;
    assign o_out_char    = r_run.chars[r_idx];
    assign o_last_of_run = at_last;

endmodule

>>> sv/json_string_escape_cp1252.sv
// ----------------------------------------------------------------------------
// json_string_escape_cp1252
// json string escaper for cp1252 text, one input byte in, one ascii char out
// ----------------------------------------------------------------------------
//
//  channel   valid    stall    payload
//  input     i_valid  o_stall  i_in_byte[7:0]
//  output    o_valid  i_stall  o_out_char[6:0], o_last_of_run
//
//  a byte becomes 1, 2 or 6 output characters (plain, short escape, \u form);
//  the output port moves one character per cycle while i_stall is low, so
//  that port sets the rate.
//  a byte waits in the input register while the run register drains, and the
//  next run loads in the cycle the final character of the previous one goes.
//  reset (synchronous, active low) empties both registers.
//
module json_string_escape_cp1252 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_of_run
);
    import jse_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       n_in_valid;
    logic       load;
    logic       in_take;
    t_run       run;

    // the input register frees up whenever its byte moves to the run register
    assign o_stall = r_in_valid && !load;
    assign in_take = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    // byte to escaped run, between input register and run register
    jse_encode u_encode (
        .i_byte (r_in_byte),
        .o_run  (run)
    );

    // run register and character sequencing
    jse_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run_valid   (r_in_valid),
        .i_run         (run),
        .o_load        (load),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule
